/* hdl/swtd_pkg.sv */
// ----------------------------------------------------------------------------
// swtd_pkg
// Shared types and constants for the sync-word TLV deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package swtd_pkg;

   // parse phases
   localparam logic [1:0] PH_HUNT    = 2'd0;
   localparam logic [1:0] PH_HEADER  = 2'd1;
   localparam logic [1:0] PH_TLV_HDR = 2'd2;
   localparam logic [1:0] PH_PAYLOAD = 2'd3;

   localparam int unsigned SYNC_LEN    = 8;
   localparam int unsigned HEADER_LEN  = 32;
   localparam int unsigned TLV_HDR_LEN = 8;
   localparam int unsigned RECORD_LEN  = 16;

   localparam logic [31:0] OBJECT_TLV_RESET = 32'd6;
   localparam logic [15:0] EMIT_SAT         = 16'hFFFF;

   // sync word, first byte on the wire first
   function automatic logic [7:0] sync_byte(input logic [2:0] idx);
      logic [7:0] b;
      case (idx)
         3'd0:    b = 8'h02;
         3'd1:    b = 8'h01;
         3'd2:    b = 8'h04;
         3'd3:    b = 8'h03;
         3'd4:    b = 8'h06;
         3'd5:    b = 8'h05;
         3'd6:    b = 8'h08;
         3'd7:    b = 8'h07;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   // one detected object
   typedef struct packed {
      logic [31:0] frame_number;
      logic [15:0] object_index;
      logic [31:0] x_bits;
      logic [31:0] y_bits;
      logic [31:0] z_bits;
      logic [31:0] velocity_bits;
      logic        last_object;
   } obj_type;

   // byte handed from the input register to the parser
   typedef struct packed {
      logic       fire;
      logic [7:0] data;
   } stage_type;

   // parser result for the output register
   typedef struct packed {
      logic    emit;
      obj_type obj;
   } result_type;

endpackage

`default_nettype wire

/* hdl/swtd_if.sv */
// ----------------------------------------------------------------------------
// swtd_if
// Valid/ready channel interfaces for received bytes and object results.
// ----------------------------------------------------------------------------
`default_nettype none

interface swtd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface swtd_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] frame_number;
   logic [15:0] object_index;
   logic [31:0] x_bits;
   logic [31:0] y_bits;
   logic [31:0] z_bits;
   logic [31:0] velocity_bits;
   logic        last_object;

   modport source (output valid, output frame_number, output object_index,
                   output x_bits, output y_bits, output z_bits,
                   output velocity_bits, output last_object, input ready);
   modport sink   (input valid, input frame_number, input object_index,
                   input x_bits, input y_bits, input z_bits,
                   input velocity_bits, input last_object, output ready);
endinterface

`default_nettype wire

/* hdl/swtd_in_stage.sv */
// ----------------------------------------------------------------------------
// swtd_in_stage
// Input byte register; releases its byte when the result slot is free.
// ----------------------------------------------------------------------------
`default_nettype none

module swtd_in_stage (
   input  wire                 clock,
   input  wire                 reset,
   swtd_req_if.sink            req_chan,
   input  wire                 slot_free,
   output swtd_pkg::stage_type stage
);

   logic       vld_ff, vld_in;
   logic [7:0] data_ff, data_in;
   logic       fire;
   logic       take;

   assign fire           = vld_ff & slot_free;
   assign req_chan.ready = ~vld_ff | fire;
   assign take           = req_chan.valid & req_chan.ready;

   always_comb begin
      vld_in  = vld_ff;
      data_in = data_ff;
      if (take) begin
         vld_in  = 1'b1;
         data_in = req_chan.rx_byte;
      end else if (fire) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      data_ff <= data_in;
   end

   assign stage.fire = fire;
   assign stage.data = data_ff;

endmodule

`default_nettype wire

/* hdl/swtd_parser.sv */
// ----------------------------------------------------------------------------
// swtd_parser
// Sync hunt, frame header, TLV walk and record assembly, one byte per fire.
// ----------------------------------------------------------------------------
`default_nettype none

module swtd_parser (
   input  wire                  clock,
   input  wire                  reset,
   input  swtd_pkg::stage_type  stage,
   input  wire  [31:0]          obj_tlv_type,
   output swtd_pkg::result_type result
);

   logic [1:0]  phase_ff,     phase_in;
   logic [3:0]  sync_prog_ff, sync_prog_in;
   logic [5:0]  byte_pos_ff,  byte_pos_in;
   logic [31:0] word_asm_ff,  word_asm_in;
   logic [31:0] frame_ff,     frame_in;
   logic [31:0] announced_ff, announced_in;
   logic [31:0] tlvs_ff,      tlvs_in;
   logic [31:0] tlv_type_ff,  tlv_type_in;
   logic [31:0] pay_rem_ff,   pay_rem_in;
   logic [15:0] emitted_ff,   emitted_in;
   logic [31:0] rec_ff [3];
   logic [31:0] rec_in [3];

   logic [7:0]  b;
   logic [3:0]  prog_nxt;
   logic [5:0]  pos_inc;
   logic [31:0] tlvs_dec;
   logic [1:0]  phase_done;
   logic [31:0] emitted_ext;
   logic        emit;
   logic        last;

   assign b           = stage.data;
   assign pos_inc     = byte_pos_ff + 6'd1;
   assign tlvs_dec    = tlvs_ff - 32'd1;
   assign phase_done  = (tlvs_dec == 32'd0) ? swtd_pkg::PH_HUNT : swtd_pkg::PH_TLV_HDR;
   assign emitted_ext = {16'd0, emitted_ff};

   always_comb begin
      phase_in     = phase_ff;
      sync_prog_in = sync_prog_ff;
      byte_pos_in  = byte_pos_ff;
      word_asm_in  = {b, word_asm_ff[31:8]};
      frame_in     = frame_ff;
      announced_in = announced_ff;
      tlvs_in      = tlvs_ff;
      tlv_type_in  = tlv_type_ff;
      pay_rem_in   = pay_rem_ff;
      emitted_in   = emitted_ff;
      rec_in       = rec_ff;
      prog_nxt     = 4'd0;
      emit         = 1'b0;
      last         = 1'b0;

      case (phase_ff)
         swtd_pkg::PH_HUNT: begin
            word_asm_in = word_asm_ff;   // hunting does not shift bytes in
            if (b == swtd_pkg::sync_byte(sync_prog_ff[2:0])) begin
               prog_nxt = sync_prog_ff + 4'd1;
            end else begin
               prog_nxt = {3'd0, (b == swtd_pkg::sync_byte(3'd0))};
            end
            if (prog_nxt >= 4'(swtd_pkg::SYNC_LEN)) begin
               sync_prog_in = 4'd0;
               byte_pos_in  = 6'd0;
               phase_in     = swtd_pkg::PH_HEADER;
            end else begin
               sync_prog_in = prog_nxt;
            end
         end

         swtd_pkg::PH_HEADER: begin
            // word 3 frame number, word 5 object count, word 6 TLV count
            if (byte_pos_ff[1:0] == 2'd3) begin
               case (byte_pos_ff[4:2])
                  3'd3:    frame_in     = word_asm_in;
                  3'd5:    announced_in = word_asm_in;
                  3'd6:    tlvs_in      = word_asm_in;
                  default: ;
               endcase
            end
            byte_pos_in = pos_inc;
            if (pos_inc >= 6'(swtd_pkg::HEADER_LEN)) begin
               byte_pos_in = 6'd0;
               phase_in    = (tlvs_in == 32'd0) ? swtd_pkg::PH_HUNT : swtd_pkg::PH_TLV_HDR;
            end
         end

         swtd_pkg::PH_TLV_HDR: begin
            if (byte_pos_ff == 6'd3) begin
               tlv_type_in = word_asm_in;
            end else if (byte_pos_ff == 6'd7) begin
               // length includes the 8-byte TLV header
               pay_rem_in = (word_asm_in < 32'(swtd_pkg::TLV_HDR_LEN)) ? 32'd0 :
                            word_asm_in - 32'(swtd_pkg::TLV_HDR_LEN);
            end
            byte_pos_in = pos_inc;
            if (pos_inc >= 6'(swtd_pkg::TLV_HDR_LEN)) begin
               byte_pos_in = 6'd0;
               emitted_in  = 16'd0;
               if (pay_rem_in == 32'd0) begin
                  tlvs_in      = tlvs_dec;
                  phase_in     = phase_done;
                  sync_prog_in = 4'd0;
               end else begin
                  phase_in = swtd_pkg::PH_PAYLOAD;
               end
            end
         end

         swtd_pkg::PH_PAYLOAD: begin
            pay_rem_in = pay_rem_ff - 32'd1;
            if (byte_pos_ff[1:0] == 2'd3 && byte_pos_ff[3:2] != 2'd3) begin
               rec_in[byte_pos_ff[3:2]] = word_asm_in;
            end
            byte_pos_in = {2'd0, pos_inc[3:0]};
            // record complete on its 16th byte
            if (byte_pos_ff[3:0] == 4'hF && tlv_type_ff == obj_tlv_type &&
                emitted_ext < announced_ff) begin
               emit = 1'b1;
               last = (pay_rem_in < 32'(swtd_pkg::RECORD_LEN)) ||
                      (emitted_ff != swtd_pkg::EMIT_SAT &&
                       emitted_ext + 32'd1 >= announced_ff);
               if (emitted_ff != swtd_pkg::EMIT_SAT) begin
                  emitted_in = emitted_ff + 16'd1;
               end
            end
            if (pay_rem_in == 32'd0) begin
               tlvs_in      = tlvs_dec;
               byte_pos_in  = 6'd0;
               phase_in     = phase_done;
               sync_prog_in = 4'd0;
            end
         end

         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= swtd_pkg::PH_HUNT;
         sync_prog_ff <= 4'd0;
         byte_pos_ff  <= 6'd0;
         word_asm_ff  <= 32'd0;
         frame_ff     <= 32'd0;
         announced_ff <= 32'd0;
         tlvs_ff      <= 32'd0;
         tlv_type_ff  <= 32'd0;
         pay_rem_ff   <= 32'd0;
         emitted_ff   <= 16'd0;
      end else if (stage.fire) begin
         phase_ff     <= phase_in;
         sync_prog_ff <= sync_prog_in;
         byte_pos_ff  <= byte_pos_in;
         word_asm_ff  <= word_asm_in;
         frame_ff     <= frame_in;
         announced_ff <= announced_in;
         tlvs_ff      <= tlvs_in;
         tlv_type_ff  <= tlv_type_in;
         pay_rem_ff   <= pay_rem_in;
         emitted_ff   <= emitted_in;
      end
      if (stage.fire) begin
         rec_ff <= rec_in;
      end
   end

   assign result.emit              = stage.fire & emit;
   assign result.obj.frame_number  = frame_ff;
   assign result.obj.object_index  = emitted_ff;
   assign result.obj.x_bits        = rec_ff[0];
   assign result.obj.y_bits        = rec_ff[1];
   assign result.obj.z_bits        = rec_in[2];
   assign result.obj.velocity_bits = word_asm_in;
   assign result.obj.last_object   = last;

endmodule

`default_nettype wire

/* hdl/swtd_out_reg.sv */
// ----------------------------------------------------------------------------
// swtd_out_reg
// Result register driving the response channel.
// ----------------------------------------------------------------------------
`default_nettype none

module swtd_out_reg (
   input  wire                  clock,
   input  wire                  reset,
   input  swtd_pkg::result_type result,
   input  wire                  fire,
   output logic                 slot_free,
   swtd_rsp_if.source           rsp_chan
);

   logic              vld_ff, vld_in;
   swtd_pkg::obj_type obj_ff, obj_in;

   assign slot_free = ~vld_ff | rsp_chan.ready;

   always_comb begin
      vld_in = vld_ff;
      obj_in = obj_ff;
      if (fire) begin
         vld_in = result.emit;
         obj_in = result.obj;
      end else if (rsp_chan.ready) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      obj_ff <= obj_in;
   end

   assign rsp_chan.valid         = vld_ff;
   assign rsp_chan.frame_number  = obj_ff.frame_number;
   assign rsp_chan.object_index  = obj_ff.object_index;
   assign rsp_chan.x_bits        = obj_ff.x_bits;
   assign rsp_chan.y_bits        = obj_ff.y_bits;
   assign rsp_chan.z_bits        = obj_ff.z_bits;
   assign rsp_chan.velocity_bits = obj_ff.velocity_bits;
   assign rsp_chan.last_object   = obj_ff.last_object;

endmodule

`default_nettype wire

/* hdl/sync_word_tlv_deframer.sv */
// ----------------------------------------------------------------------------
// sync_word_tlv_deframer
// Byte-stream deframer: sync hunt, frame header, TLV walk, object records.
// ----------------------------------------------------------------------------
// Takes one received byte per transfer and sustains one byte per clock while
// rsp is not stalled. Each byte is registered at its transfer and parsed
// between the input register and the result register, which holds the
// object of each 16-byte record for rsp. The block hunts for the sync
// word 02 01 04 03 06 05 08 07, reads the 32-byte little-endian frame header
// (frame number, object count, TLV count), then walks the TLVs. In each TLV
// whose type matches csr_wr_data as last written (reset 6), every complete
// record gives one object transfer carrying raw x/y/z/velocity words; at most
// the announced count is emitted per TLV, last_object flags the final one. The
// req side only stalls while a result waits on a stalled rsp side. Write the
// CSR only while no byte is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module sync_word_tlv_deframer (
   input  wire         clock,
   input  wire         reset,
   swtd_req_if.sink    req_chan,
   swtd_rsp_if.source  rsp_chan,
   input  wire         csr_wr_en,
   input  wire  [31:0] csr_wr_data
);

   logic [31:0]          obj_type_ff, obj_type_in;
   swtd_pkg::stage_type  stage;
   swtd_pkg::result_type result;
   logic                 slot_free;

   // object TLV type register; the parser sees a write once it is registered
   assign obj_type_in = csr_wr_en ? csr_wr_data : obj_type_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         obj_type_ff <= swtd_pkg::OBJECT_TLV_RESET;
      end else begin
         obj_type_ff <= obj_type_in;
      end
   end

   // input register: one byte, released when the result slot is free
   swtd_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .slot_free (slot_free),
      .stage     (stage)
   );

   // frame walk and record assembly
   swtd_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .stage        (stage),
      .obj_tlv_type (obj_type_ff),
      .result       (result)
   );

   // result register toward the consumer
   swtd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .result    (result),
      .fire      (stage.fire),
      .slot_free (slot_free),
      .rsp_chan  (rsp_chan)
   );

endmodule

`default_nettype wire

/* hdl/swtd_checker.sv */
// ----------------------------------------------------------------------------
// swtd_checker
// Port-level checks for the deframer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module swtd_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_valid,
   input wire        req_ready,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire [31:0] frame_number,
   input wire [15:0] object_index,
   input wire [31:0] x_bits,
   input wire [31:0] y_bits,
   input wire [31:0] z_bits,
   input wire [31:0] velocity_bits,
   input wire        last_object
);

   // held result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(frame_number) &&
      $stable(object_index) && $stable(x_bits) && $stable(y_bits) &&
      $stable(z_bits) && $stable(velocity_bits) && $stable(last_object))
      else $error("rsp payload changed while stalled");

   // reset empties the result register
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // input only stalls behind a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("req stalled without rsp backpressure");

   // records are 16 bytes apart, so results never come back to back
   a_no_b2b: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> !rsp_valid)
      else $error("results in consecutive cycles");

endmodule

bind sync_word_tlv_deframer swtd_checker u_swtd_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .frame_number  (rsp_chan.frame_number),
   .object_index  (rsp_chan.object_index),
   .x_bits        (rsp_chan.x_bits),
   .y_bits        (rsp_chan.y_bits),
   .z_bits        (rsp_chan.z_bits),
   .velocity_bits (rsp_chan.velocity_bits),
   .last_object   (rsp_chan.last_object)
);

`default_nettype wire

/* tb/tb_sync_word_tlv_deframer.sv */
// ----------------------------------------------------------------------------
// tb_sync_word_tlv_deframer
// Self-checking bench for the sync-word TLV deframer.
// ----------------------------------------------------------------------------
// Feeds byte streams built from well-formed frames, broken sync prefixes and
// line noise. Every accepted byte goes through an in-bench parser that keeps
// its own copy of the frame state and queues the objects it expects. Each
// object transfer on rsp is checked field by field against the oldest entry.
// Phases change the object TLV type and the idle/stall mix on both sides.
// ----------------------------------------------------------------------------

module tb_sync_word_tlv_deframer;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_HALF      = 4;
   localparam int RESET_CYCLES  = 9;
   localparam int QUIET_CYCLES  = 8;     // covers the two-stage pipe with margin
   localparam int LONG_HOLD     = 300;   // rsp hold-off, long enough to back up req
   localparam int PHASE_BYTES   = 150;
   localparam int PHASE_OBJECTS = 2;

   // frame header word slots
   localparam int HDR_WORD_FRAME   = 3;
   localparam int HDR_WORD_OBJECTS = 5;
   localparam int HDR_WORD_TLVS    = 6;

   // sync word, first byte on the wire in the low byte
   localparam logic [63:0] SYNC_PATTERN = 64'h0708_0506_0304_0102;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en;
   logic [31:0] csr_wr_data;

   swtd_req_if req_if ();
   swtd_rsp_if rsp_if ();

   sync_word_tlv_deframer u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #(CLK_HALF) clock = ~clock;

   // ---------------------------------------------------------------------
   // Bench state
   // ---------------------------------------------------------------------
   logic [7:0]        rx_stream[$];          // bytes waiting to be offered on req
   swtd_pkg::obj_type pending_objects[$];    // objects the parser says must come out
   int                bytes_queued;
   int                objects_planned;       // rough count, only steers frame generation
   int                send_idle_pct;
   int                recv_stall_pct;
   int                error_count = 0;
   logic              rsp_hold;
   logic              long_hold_req = 1'b0;

   // parser copy: object TLV type and frame walk state
   logic [31:0] tlv_type_cfg;
   logic [1:0]  parse_ph;
   logic [3:0]  hunt_count;
   logic [5:0]  byte_idx;
   logic [31:0] shift_word;
   logic [31:0] cur_frame;
   logic [31:0] obj_announced;
   logic [31:0] tlv_left;
   logic [31:0] cur_type;
   logic [31:0] pay_left;
   logic [15:0] obj_count;
   logic [31:0] rec_word [0:2];

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      $display("%0t ns: %s mismatch, got %h expected %h", $time, what, got, want);
   endtask

   // ---------------------------------------------------------------------
   // Parser: one byte in, zero or one expected object out
   // ---------------------------------------------------------------------
   task automatic finish_tlv();
      tlv_left   = tlv_left - 32'd1;
      byte_idx   = '0;
      parse_ph   = (tlv_left == 32'd0) ? swtd_pkg::PH_HUNT : swtd_pkg::PH_TLV_HDR;
      hunt_count = '0;
   endtask

   task automatic deframe_byte(input logic [7:0] b);
      swtd_pkg::obj_type o;
      if (parse_ph != swtd_pkg::PH_HUNT)
         shift_word = {b, shift_word[31:8]};   // little-endian word assembly
      case (parse_ph)
         swtd_pkg::PH_HUNT: begin
            // a mismatch restarts at one only on the leading sync byte
            if (b == SYNC_PATTERN[8*hunt_count[2:0] +: 8])
               hunt_count = hunt_count + 4'd1;
            else
               hunt_count = (b == SYNC_PATTERN[7:0]) ? 4'd1 : 4'd0;
            if (hunt_count >= swtd_pkg::SYNC_LEN) begin
               hunt_count = '0;
               byte_idx   = '0;
               parse_ph   = swtd_pkg::PH_HEADER;
            end
         end
         swtd_pkg::PH_HEADER: begin
            if (byte_idx[1:0] == 2'd3) begin
               case (int'(byte_idx[5:2]))
                  HDR_WORD_FRAME:   cur_frame     = shift_word;
                  HDR_WORD_OBJECTS: obj_announced = shift_word;
                  HDR_WORD_TLVS:    tlv_left      = shift_word;
                  default: ;
               endcase
            end
            byte_idx = byte_idx + 6'd1;
            if (byte_idx >= swtd_pkg::HEADER_LEN) begin
               byte_idx = '0;
               parse_ph = (tlv_left == 32'd0) ? swtd_pkg::PH_HUNT : swtd_pkg::PH_TLV_HDR;
            end
         end
         swtd_pkg::PH_TLV_HDR: begin
            // length counts the 8 header bytes; shorter means empty payload
            if (byte_idx == 6'd3)
               cur_type = shift_word;
            else if (byte_idx == 6'd7)
               pay_left = (shift_word < swtd_pkg::TLV_HDR_LEN) ? 32'd0 :
                          shift_word - swtd_pkg::TLV_HDR_LEN;
            byte_idx = byte_idx + 6'd1;
            if (byte_idx >= swtd_pkg::TLV_HDR_LEN) begin
               byte_idx  = '0;
               obj_count = '0;
               if (pay_left == 32'd0)
                  finish_tlv();
               else
                  parse_ph = swtd_pkg::PH_PAYLOAD;
            end
         end
         default: begin
            pay_left = pay_left - 32'd1;
            if (byte_idx[1:0] == 2'd3 && byte_idx[3:2] != 2'd3)
               rec_word[byte_idx[3:2]] = shift_word;
            byte_idx = {2'b00, byte_idx[3:0] + 4'd1};
            // full record of the selected type, count not yet reached
            if (byte_idx == 6'd0 && cur_type == tlv_type_cfg &&
                {16'd0, obj_count} < obj_announced) begin
               o.frame_number  = cur_frame;
               o.object_index  = obj_count;
               o.x_bits        = rec_word[0];
               o.y_bits        = rec_word[1];
               o.z_bits        = rec_word[2];
               o.velocity_bits = shift_word;
               o.last_object   = (pay_left < swtd_pkg::RECORD_LEN) ||
                                 (obj_count != swtd_pkg::EMIT_SAT &&
                                  {16'd0, obj_count} + 32'd1 >= obj_announced);
               pending_objects.push_back(o);
               if (obj_count != swtd_pkg::EMIT_SAT)
                  obj_count = obj_count + 16'd1;
            end
            if (pay_left == 32'd0)
               finish_tlv();
         end
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Stream builders
   // ---------------------------------------------------------------------
   task automatic push_byte(input logic [7:0] b);
      rx_stream.push_back(b);
      bytes_queued++;
   endtask

   task automatic push_word(input logic [31:0] w);
      for (int i = 0; i < 4; i++)
         push_byte(w[8*i +: 8]);
   endtask

   task automatic push_sync();
      push_word(SYNC_PATTERN[31:0]);
      push_word(SYNC_PATTERN[63:32]);
   endtask

   // remaining header words carry random filler
   task automatic push_header(input logic [31:0] frame, input logic [31:0] nobj,
                              input logic [31:0] ntlv);
      for (int w = 0; w < 8; w++) begin
         case (w)
            HDR_WORD_FRAME:   push_word(frame);
            HDR_WORD_OBJECTS: push_word(nobj);
            HDR_WORD_TLVS:    push_word(ntlv);
            default:          push_word($urandom);
         endcase
      end
   endtask

   // fill below zero means random payload bytes
   task automatic push_tlv(input logic [31:0] code, input logic [31:0] len,
                           input logic [31:0] nobj, input int fill);
      int unsigned n;
      n = (len < swtd_pkg::TLV_HDR_LEN) ? 0 : len - swtd_pkg::TLV_HDR_LEN;
      push_word(code);
      push_word(len);
      for (int unsigned i = 0; i < n; i++)
         push_byte(8'((fill < 0) ? $urandom_range(255) : fill));
      if (code == tlv_type_cfg)
         objects_planned += (nobj < n / swtd_pkg::RECORD_LEN) ? nobj :
                            n / swtd_pkg::RECORD_LEN;
   endtask

   task automatic push_random_frame();
      logic [31:0] nobj;
      logic [31:0] ntlv;
      logic [31:0] code;
      logic [31:0] len;
      int          sel;
      int          k;
      // leading junk in some frames: plain noise or a sync prefix that breaks off
      sel = $urandom_range(9);
      if (sel < 2) begin
         repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(255)));
      end else if (sel < 4) begin
         k = $urandom_range(1, 7);
         for (int i = 0; i < k; i++)
            push_byte(SYNC_PATTERN[8*i +: 8]);
         push_byte(8'($urandom_range(255)));
      end
      nobj = ($urandom_range(7) == 0) ? $urandom : $urandom_range(0, 5);
      ntlv = ($urandom_range(7) == 0) ? 32'd0 : $urandom_range(1, 3);
      push_sync();
      push_header($urandom, nobj, ntlv);
      for (int t = 0; t < ntlv; t++) begin
         code = ($urandom_range(9) < 7) ? tlv_type_cfg : $urandom;
         sel  = $urandom_range(9);
         if (sel == 0)
            len = $urandom_range(0, 8);
         else
            len = swtd_pkg::TLV_HDR_LEN + swtd_pkg::RECORD_LEN * $urandom_range(0, 4) +
                  ((sel < 4) ? $urandom_range(1, 15) : 0);
         push_tlv(code, len, nobj, -1);
      end
   endtask

   // ---------------------------------------------------------------------
   // Sequencing helpers
   // ---------------------------------------------------------------------
   // sampled on the falling edge so the driver and monitor have settled
   task automatic wait_idle();
      @(negedge clock);
      while (rx_stream.size() != 0 || req_if.valid || pending_objects.size() != 0)
         @(negedge clock);
      repeat (QUIET_CYCLES) @(negedge clock);
   endtask

   task automatic write_tlv_type(input logic [31:0] v);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      tlv_type_cfg = v;
   endtask

   task automatic run_phase(input logic [31:0] cfg, input int idle, input int stall,
                            input bit long_hold);
      write_tlv_type(cfg);
      send_idle_pct   = idle;
      recv_stall_pct  = stall;
      bytes_queued    = 0;
      objects_planned = 0;
      if (long_hold) begin
         // an object TLV queued up front while rsp is held off
         long_hold_req = 1'b1;
         push_sync();
         push_header($urandom, 32'hFFFF_FFFF, 32'd1);
         push_tlv(cfg, swtd_pkg::TLV_HDR_LEN + 4 * swtd_pkg::RECORD_LEN, 32'hFFFF_FFFF, -1);
      end
      while (bytes_queued < PHASE_BYTES || objects_planned < PHASE_OBJECTS)
         push_random_frame();
      wait_idle();
   endtask

   // ---------------------------------------------------------------------
   // req driver: holds a byte until its transfer, then maybe idles
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready)
            deframe_byte(req_if.rx_byte);
         if (!req_if.valid || req_if.ready) begin
            if (rx_stream.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_if.valid   <= 1'b1;
               req_if.rx_byte <= rx_stream.pop_front();
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // rsp monitor: checks each object transfer, drives random ready
   // ---------------------------------------------------------------------
   task automatic check_object();
      swtd_pkg::obj_type want;
      if (pending_objects.size() == 0) begin
         report_mismatch("unexpected object, frame_number", rsp_if.frame_number, '0);
      end else begin
         want = pending_objects.pop_front();
         if (rsp_if.frame_number !== want.frame_number)
            report_mismatch("frame_number", rsp_if.frame_number, want.frame_number);
         if (rsp_if.object_index !== want.object_index)
            report_mismatch("object_index", rsp_if.object_index, want.object_index);
         if (rsp_if.x_bits !== want.x_bits)
            report_mismatch("x_bits", rsp_if.x_bits, want.x_bits);
         if (rsp_if.y_bits !== want.y_bits)
            report_mismatch("y_bits", rsp_if.y_bits, want.y_bits);
         if (rsp_if.z_bits !== want.z_bits)
            report_mismatch("z_bits", rsp_if.z_bits, want.z_bits);
         if (rsp_if.velocity_bits !== want.velocity_bits)
            report_mismatch("velocity_bits", rsp_if.velocity_bits, want.velocity_bits);
         if (rsp_if.last_object !== want.last_object)
            report_mismatch("last_object", rsp_if.last_object, want.last_object);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready)
            check_object();
         rsp_if.ready <= !rsp_hold && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // long rsp hold-off, counted here so req keeps streaming meanwhile
   initial begin
      rsp_hold = 1'b0;
      forever begin
         wait (long_hold_req);
         long_hold_req = 1'b0;
         @(posedge clock);
         rsp_hold <= 1'b1;
         repeat (LONG_HOLD) @(posedge clock);
         rsp_hold <= 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      req_if.valid   = 1'b0;
      req_if.rx_byte = 8'h00;
      rsp_if.ready   = 1'b0;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;

      // parser copy starts where reset leaves the block
      tlv_type_cfg  = swtd_pkg::OBJECT_TLV_RESET;
      parse_ph      = swtd_pkg::PH_HUNT;
      hunt_count    = '0;
      byte_idx      = '0;
      shift_word    = '0;
      cur_frame     = '0;
      obj_announced = '0;
      tlv_left      = '0;
      cur_type      = '0;
      pay_left      = '0;
      obj_count     = '0;
      rec_word[0]   = '0;
      rec_word[1]   = '0;
      rec_word[2]   = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed frames, reset type, no idling.
      // Leading sync byte repeated mid-hunt, then a frame with no TLVs.
      push_byte(8'h02);
      push_byte(8'h01);
      push_sync();
      push_header(32'hFFFF_FFFF, 32'd3, 32'd0);
      // Short lengths (0 and 7), count reached with a partial trailing record,
      // then a TLV of another type that must stay silent.
      push_sync();
      push_header(32'd0, 32'd2, 32'd4);
      push_tlv(swtd_pkg::OBJECT_TLV_RESET, 32'd0, 32'd2, -1);
      push_tlv(swtd_pkg::OBJECT_TLV_RESET, 32'd7, 32'd2, -1);
      push_tlv(swtd_pkg::OBJECT_TLV_RESET,
               swtd_pkg::TLV_HDR_LEN + 3 * swtd_pkg::RECORD_LEN + 5, 32'd2, -1);
      push_tlv(32'd5, swtd_pkg::TLV_HDR_LEN + swtd_pkg::RECORD_LEN, 32'd2, -1);
      // Count never limits: last flag comes from the payload end. All-ones
      // and all-zeros records hit the byte extremes.
      push_sync();
      push_header(32'h8000_0001, 32'hFFFF_FFFF, 32'd2);
      push_tlv(swtd_pkg::OBJECT_TLV_RESET, swtd_pkg::TLV_HDR_LEN + swtd_pkg::RECORD_LEN,
               32'hFFFF_FFFF, 255);
      push_tlv(swtd_pkg::OBJECT_TLV_RESET,
               swtd_pkg::TLV_HDR_LEN + 2 * swtd_pkg::RECORD_LEN + 15, 32'hFFFF_FFFF, 0);
      wait_idle();

      // Random phases: type extremes and idle/stall mixes.
      run_phase(32'd0, 0, 0, 1'b0);
      run_phase(32'hFFFF_FFFF, 55, 0, 1'b0);
      run_phase($urandom, 0, 55, 1'b0);
      run_phase(swtd_pkg::OBJECT_TLV_RESET, 15, 15, 1'b0);
      run_phase($urandom, 0, 0, 1'b1);

      if (error_count == 0 && pending_objects.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // hang guard, far above the slowest legal run
   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
